// ===== hdl/srrc_pkg.sv =====
package srrc_pkg;

    // Rate limits and range edges in symbols per second
    localparam int unsigned RATE_W     = 25;
    localparam logic [31:0] RATE_MAX   = 32'd32000000;
    localparam logic [31:0] RATE_MIN   = 32'd500000;
    localparam logic [24:0] EDGE_HIGH  = 25'd24000000;
    localparam logic [24:0] EDGE_MID   = 25'd16000000;

    // Dividend is RATIO_NUMER * 2^32: its low 32 bits are zero
    localparam logic [24:0] RATIO_NUMER = 25'd31250;

    // Quotient bits produced by the long division and the cut into stages
    localparam int unsigned QUOT_W          = 32;
    localparam int unsigned RATIO_W         = 29;
    localparam int unsigned STEPS_PER_STAGE = 4;
    localparam int unsigned DIV_STAGES      = QUOT_W / STEPS_PER_STAGE;

    // Range codes
    localparam logic [1:0] RANGE_HIGH = 2'd0;
    localparam logic [1:0] RANGE_MID  = 2'd2;
    localparam logic [1:0] RANGE_LOW  = 2'd3;

    // Payload carried from stage to stage
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [1:0]        code;
        logic [RATE_W-1:0] rem;
        logic [QUOT_W-1:0] quot;
    } srrc_beat_t;

endpackage

// ===== hdl/srrc_clamp.sv =====
module srrc_clamp
    import srrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_rate,
    output logic        out_valid,
    input  logic        out_ready,
    output srrc_beat_t  out_beat
);

    logic       valid_reg;
    srrc_beat_t beat_reg;
    srrc_beat_t beat_next;
    logic [31:0] rate_wide;

    // Clamp the rate, pick the range code and seed the divider
    always_comb
    begin
        if (in_rate > RATE_MAX)
        begin
            rate_wide = RATE_MAX;
        end
        else if (in_rate < RATE_MIN)
        begin
            rate_wide = RATE_MIN;
        end
        else
        begin
            rate_wide = in_rate;
        end

        beat_next.rate = rate_wide[RATE_W-1:0];
        if (beat_next.rate < EDGE_MID)
        begin
            beat_next.code = RANGE_LOW;
        end
        else if (beat_next.rate < EDGE_HIGH)
        begin
            beat_next.code = RANGE_MID;
        end
        else
        begin
            beat_next.code = RANGE_HIGH;
        end
        beat_next.rem  = RATIO_NUMER;
        beat_next.quot = '0;
    end

    // Take a new beat whenever this stage is empty or drains
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== hdl/srrc_div_stage.sv =====
module srrc_div_stage
    import srrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  srrc_beat_t in_beat,
    output logic       out_valid,
    input  logic       out_ready,
    output srrc_beat_t out_beat
);

    logic       valid_reg;
    srrc_beat_t beat_reg;
    srrc_beat_t beat_next;
    logic [RATE_W:0]   trial;
    logic [RATE_W-1:0] rem_work;
    logic [QUOT_W-1:0] quot_work;

    // Restoring division: shift in a zero dividend bit, subtract where it fits
    always_comb
    begin
        rem_work  = in_beat.rem;
        quot_work = in_beat.quot;
        trial     = '0;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            trial = {rem_work, 1'b0};
            if (trial >= {1'b0, in_beat.rate})
            begin
                trial     = trial - {1'b0, in_beat.rate};
                quot_work = {quot_work[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                quot_work = {quot_work[QUOT_W-2:0], 1'b0};
            end
            rem_work = trial[RATE_W-1:0];
        end
        beat_next      = in_beat;
        beat_next.rem  = rem_work;
        beat_next.quot = quot_work;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== hdl/symbol_rate_ratio_calculator.sv =====
// Symbol rate ratio calculator. Each beat on the slave side carries a requested
// symbol rate; the block clamps it to 500000..32000000, gives a range code
// (0 at 24M and above, 2 from 16M to below 24M, 3 below 16M) and the exact
// ratio floor(31250 * 2^32 / clamped rate) on the master side, one result per
// beat, in order. A new beat is taken every cycle unless backpressure from the
// master side stalls the chain. The chain has 9 register stages: one stage for
// the clamp and range decision, then 8 divider stages that each resolve 4 of
// the 32 quotient bits. Each stage holds its beat under backpressure, so
// stalls lose nothing.
module symbol_rate_ratio_calculator
    import srrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] requested_rate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [28:0] ratio_quotient, [30:29] range_code,
                                   // [55:31] clamped_rate
);

    logic       stage_valid [0:DIV_STAGES];
    logic       stage_ready [0:DIV_STAGES+1];
    srrc_beat_t stage_beat  [0:DIV_STAGES];

    // Clamp and range decision
    srrc_clamp u_clamp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (stage_ready[0]),
        .in_rate   (s_tdata),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[1]),
        .out_beat  (stage_beat[0])
    );

    // Divider chain
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        srrc_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i+1]),
            .in_beat   (stage_beat[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+2]),
            .out_beat  (stage_beat[i+1])
        );
    end

    assign stage_ready[DIV_STAGES+1] = m_tready;
    assign s_tready = stage_ready[0];
    assign m_tvalid = stage_valid[DIV_STAGES];
    assign m_tdata  = {stage_beat[DIV_STAGES].rate,
                       stage_beat[DIV_STAGES].code,
                       stage_beat[DIV_STAGES].quot[RATIO_W-1:0]};

    // A ready sink must open the whole chain
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output sink is ready");

    // The ratio must fit its field
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (stage_beat[DIV_STAGES].quot[QUOT_W-1:RATIO_W] == '0))
        else $error("ratio overflows its field");

    // Range code agrees with the clamped rate
    a_code_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[30:29] == RANGE_LOW && m_tdata[55:31] < EDGE_MID) ||
                      (m_tdata[30:29] == RANGE_MID && m_tdata[55:31] >= EDGE_MID &&
                       m_tdata[55:31] < EDGE_HIGH) ||
                      (m_tdata[30:29] == RANGE_HIGH && m_tdata[55:31] >= EDGE_HIGH)))
        else $error("range code does not match clamped rate");

    // Remainder stays below the divisor at the end of the chain
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (stage_beat[DIV_STAGES].rem < stage_beat[DIV_STAGES].rate))
        else $error("division remainder out of bound");

endmodule

// ===== tb/sv/symbol_rate_ratio_calculator_test.sv =====
`timescale 1ns / 100ps

module symbol_rate_ratio_calculator_test;

    import srrc_pkg::*;

    // One result beat split into its fields
    typedef struct {
        logic [RATIO_W-1:0] quotient;
        logic [1:0]         range_code;
        logic [RATE_W-1:0]  clamped;
    } ratio_beat_t;

    // Kinds of requested rate drawn by the stimulus
    typedef enum int {
        PICK_FULL_WORD,
        PICK_IN_RANGE,
        PICK_NEAR_EDGE,
        PICK_BELOW_MIN,
        PICK_MIXED
    } rate_pick_t;

    // Receiver ready patterns
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_THREE
    } rx_mode_t;

    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          DRAIN_CYCLES    = 20;
    localparam logic [31:0] EDGE_HIGH_W     = {7'd0, EDGE_HIGH};
    localparam logic [31:0] EDGE_MID_W      = {7'd0, EDGE_MID};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;   // [31:0] requested_rate
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;            // [28:0] ratio_quotient, [30:29] range_code,
                                     // [55:31] clamped_rate

    ratio_beat_t pending_ratios[$];
    int          mismatch_count = 0;
    int          hold_cycles    = 0;

    symbol_rate_ratio_calculator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Clamp the rate, pick the range and divide 31250 * 2^32 by the clamped rate
    function automatic ratio_beat_t predict_ratio(input logic [31:0] requested);
        ratio_beat_t result;
        logic [31:0] rate;
        logic [63:0] dividend;
        logic [63:0] quotient;
        rate = requested;
        if (rate > RATE_MAX)
            rate = RATE_MAX;
        if (rate < RATE_MIN)
            rate = RATE_MIN;
        if (rate < EDGE_MID_W)
            result.range_code = RANGE_LOW;
        else if (rate < EDGE_HIGH_W)
            result.range_code = RANGE_MID;
        else
            result.range_code = RANGE_HIGH;
        dividend = {7'd0, RATIO_NUMER, 32'd0};
        quotient = dividend / {32'd0, rate};
        result.quotient = quotient[RATIO_W-1:0];
        result.clamped  = rate[RATE_W-1:0];
        return result;
    endfunction

    function automatic logic [31:0] pick_rate(input rate_pick_t kind);
        logic [31:0] centre;
        int          roll;
        case (kind)
            PICK_FULL_WORD:
                return $urandom;
            PICK_IN_RANGE:
                return $urandom_range(RATE_MAX, RATE_MIN);
            PICK_BELOW_MIN:
                return $urandom_range(RATE_MIN - 1, 0);
            PICK_NEAR_EDGE:
            begin
                case ($urandom_range(3, 0))
                    0:       centre = RATE_MIN;
                    1:       centre = EDGE_MID_W;
                    2:       centre = EDGE_HIGH_W;
                    default: centre = RATE_MAX;
                endcase
                return centre + $urandom_range(16, 0) - 8;
            end
            default:
            begin
                roll = $urandom_range(99, 0);
                if (roll < 50)
                    return pick_rate(PICK_IN_RANGE);
                else if (roll < 70)
                    return pick_rate(PICK_NEAR_EDGE);
                else if (roll < 85)
                    return pick_rate(PICK_BELOW_MIN);
                else
                    return pick_rate(PICK_FULL_WORD);
            end
        endcase
    endfunction

    // Offer one rate and hold it until the block takes the beat
    task automatic send_rate(input logic [31:0] rate);
        s_tvalid <= 1'b1;
        s_tdata  <= rate;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_ratios.push_back(predict_ratio(rate));
    endtask

    // Drop valid for one cycle so the next offer starts in a fresh step
    task automatic idle_sender;
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain;
        while (pending_ratios.size() != 0)
            @(posedge clk);
    endtask

    // Send in bursts of random length, with random gaps or none at all
    task automatic send_bursts(input int count, input rate_pick_t kind);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(16, 1);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_rate(pick_rate(kind));
                sent++;
            end
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                repeat (gap)
                    @(posedge clk);
            end
        end
        idle_sender();
    endtask

    task automatic test_edges_directed;
        logic [31:0] rates[$];
        rates = '{32'd0, 32'd1, 32'd3, RATE_MIN - 1, RATE_MIN, RATE_MIN + 1,
                  32'd1000000, EDGE_MID_W - 1, EDGE_MID_W, EDGE_MID_W + 1,
                  EDGE_HIGH_W - 1, EDGE_HIGH_W, EDGE_HIGH_W + 1, 32'd27000000,
                  RATE_MAX - 1, RATE_MAX, RATE_MAX + 1, 32'h8000_0000,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF};
        foreach (rates[i])
            send_rate(rates[i]);
        idle_sender();
        wait_for_drain();
    endtask

    task automatic test_random_bursts;
        send_bursts(350, PICK_MIXED);
        send_bursts(40, PICK_NEAR_EDGE);
    endtask

    // Hold the receiver off and keep offering until the input stalls
    task automatic test_input_stall_fill;
        hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 40; i++)
            send_rate(pick_rate(PICK_MIXED));
        idle_sender();
        wait_for_drain();
    endtask

    // Pause the sender until every result is out, then resume
    task automatic test_drain_pause;
        send_bursts(25, PICK_IN_RANGE);
        wait_for_drain();
        send_bursts(25, PICK_MIXED);
        wait_for_drain();
    endtask

    task automatic test_full_word_random;
        send_bursts(50, PICK_FULL_WORD);
        wait_for_drain();
    endtask

    // Receiver: a long hold-off on request, otherwise a changing ready pattern
    initial
    begin
        rx_mode_t mode;
        int       cycle;
        mode  = RX_ALWAYS;
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle % 64 == 0)
                mode = rx_mode_t'($urandom_range(2, 0));
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                case (mode)
                    RX_ALWAYS:       m_tready <= 1'b1;
                    RX_COIN:         m_tready <= 1'($urandom_range(1, 0));
                    RX_ONE_IN_THREE: m_tready <= (cycle % 3 == 0);
                    default:         m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        ratio_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_ratios.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_ratios.pop_front();
                if (m_tdata[28:0] !== want.quotient)
                begin
                    $display("%0t: ratio_quotient expected %0d actual %0d",
                             $time, want.quotient, m_tdata[28:0]);
                    mismatch_count++;
                end
                if (m_tdata[30:29] !== want.range_code)
                begin
                    $display("%0t: range_code expected %0d actual %0d",
                             $time, want.range_code, m_tdata[30:29]);
                    mismatch_count++;
                end
                if (m_tdata[55:31] !== want.clamped)
                begin
                    $display("%0t: clamped_rate expected %0d actual %0d",
                             $time, want.clamped, m_tdata[55:31]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edges_directed();
        test_random_bursts();
        test_input_stall_fill();
        test_drain_pause();
        test_full_word_random();

        wait_for_drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_ratios.size() == 0)
            $display("symbol_rate_ratio_calculator verification clean");
        else
            $display("symbol_rate_ratio_calculator verification failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("symbol_rate_ratio_calculator verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/srrc_pkg.sv
hdl/srrc_clamp.sv
hdl/srrc_div_stage.sv
hdl/symbol_rate_ratio_calculator.sv
tb/sv/symbol_rate_ratio_calculator_test.sv
